FILE: rtl/assert_macros.svh
// Assertion macros shared by the noise channel RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/nlsc_pkg.sv
// Package for the noise sound channel: event and register codes,
// result struct, period and length lookup tables. No dependencies.
package nlsc_pkg;

	typedef enum logic [2:0] {
		REQ_REG_WRITE = 3'd0,
		REQ_ENABLE    = 3'd1,
		REQ_TIMER     = 3'd2,
		REQ_QUARTER   = 3'd3,
		REQ_HALF      = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		REG_VOLUME = 2'd0,
		REG_UNUSED = 2'd1,
		REG_MODE   = 2'd2,
		REG_LENGTH = 2'd3
	} reg_sel_t;

	localparam int unsigned LfsrW   = 15;
	localparam int unsigned PeriodW = 12;
	localparam int unsigned LengthW = 8;
	localparam int unsigned LevelW  = 4;
	localparam logic [3:0]  DecayMax = 4'hF;

	typedef struct packed {
		logic [LevelW-1:0] level;
		logic              length_active;
	} result_t;

	function automatic logic [PeriodW-1:0] period_lookup(input logic [3:0] idx);
		logic [PeriodW-1:0] p;
		case (idx)
			4'd0:    p = 12'd4;
			4'd1:    p = 12'd8;
			4'd2:    p = 12'd16;
			4'd3:    p = 12'd32;
			4'd4:    p = 12'd64;
			4'd5:    p = 12'd96;
			4'd6:    p = 12'd128;
			4'd7:    p = 12'd160;
			4'd8:    p = 12'd202;
			4'd9:    p = 12'd254;
			4'd10:   p = 12'd380;
			4'd11:   p = 12'd508;
			4'd12:   p = 12'd762;
			4'd13:   p = 12'd1016;
			4'd14:   p = 12'd2034;
			default: p = 12'd4068;
		endcase
		return p;
	endfunction

	function automatic logic [LengthW-1:0] length_lookup(input logic [4:0] idx);
		logic [LengthW-1:0] l;
		case (idx)
			5'd0:    l = 8'd10;
			5'd1:    l = 8'd254;
			5'd2:    l = 8'd20;
			5'd3:    l = 8'd2;
			5'd4:    l = 8'd40;
			5'd5:    l = 8'd4;
			5'd6:    l = 8'd80;
			5'd7:    l = 8'd6;
			5'd8:    l = 8'd160;
			5'd9:    l = 8'd8;
			5'd10:   l = 8'd60;
			5'd11:   l = 8'd10;
			5'd12:   l = 8'd14;
			5'd13:   l = 8'd12;
			5'd14:   l = 8'd26;
			5'd15:   l = 8'd14;
			5'd16:   l = 8'd12;
			5'd17:   l = 8'd16;
			5'd18:   l = 8'd24;
			5'd19:   l = 8'd18;
			5'd20:   l = 8'd48;
			5'd21:   l = 8'd20;
			5'd22:   l = 8'd96;
			5'd23:   l = 8'd22;
			5'd24:   l = 8'd192;
			5'd25:   l = 8'd24;
			5'd26:   l = 8'd72;
			5'd27:   l = 8'd26;
			5'd28:   l = 8'd16;
			5'd29:   l = 8'd28;
			5'd30:   l = 8'd32;
			default: l = 8'd30;
		endcase
		return l;
	endfunction

endpackage

FILE: rtl/nlsc_chan.sv
// Noise channel state: LFSR, period timer, envelope, length counter.
// Depends on nlsc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nlsc_chan (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic [2:0]        req_type,
	input  logic [1:0]        reg_sel,
	input  logic [7:0]        write_data,
	output nlsc_pkg::result_t res
);
	import nlsc_pkg::*;

	logic [LfsrW-1:0]   shift_q,  shift_d;
	logic               short_q,  short_d;
	logic [PeriodW-1:0] pcount_q, pcount_d;
	logic [PeriodW-1:0] preload_q, preload_d;
	logic [LengthW-1:0] length_q, length_d;
	logic               halt_q,   halt_d;
	logic               const_q,  const_d;
	logic [3:0]         volper_q, volper_d;
	logic               estart_q, estart_d;
	logic [3:0]         decay_q,  decay_d;
	logic [3:0]         div_q,    div_d;
	logic               en_q,     en_d;
	logic               tap;

	always_comb begin
		shift_d   = shift_q;
		short_d   = short_q;
		pcount_d  = pcount_q;
		preload_d = preload_q;
		length_d  = length_q;
		halt_d    = halt_q;
		const_d   = const_q;
		volper_d  = volper_q;
		estart_d  = estart_q;
		decay_d   = decay_q;
		div_d     = div_q;
		en_d      = en_q;
		tap       = (short_q ? shift_q[6] : shift_q[1]) ^ shift_q[0];
		case (req_t'(req_type))
			REQ_REG_WRITE: begin
				case (reg_sel_t'(reg_sel))
					REG_VOLUME: begin
						halt_d   = write_data[5];
						const_d  = write_data[4];
						volper_d = write_data[3:0];
					end
					REG_MODE: begin
						short_d   = write_data[7];
						preload_d = period_lookup(write_data[3:0]);
					end
					REG_LENGTH: begin
						if (en_q) begin
							length_d = length_lookup(write_data[7:3]);
						end
						estart_d = 1'b1;
					end
					default: ;
				endcase
			end
			REQ_ENABLE: begin
				en_d = write_data[0];
				if (!write_data[0]) begin
					length_d = '0;
				end
			end
			REQ_TIMER: begin
				if (pcount_q == '0) begin
					pcount_d = preload_q;
					shift_d  = {tap, shift_q[LfsrW-1:1]};
				end else begin
					pcount_d = pcount_q - 1'b1;
				end
			end
			REQ_QUARTER: begin
				if (estart_q) begin
					estart_d = 1'b0;
					decay_d  = DecayMax;
					div_d    = volper_q;
				end else if (div_q != '0) begin
					div_d = div_q - 1'b1;
				end else begin
					div_d = volper_q;
					if (decay_q != '0) begin
						decay_d = decay_q - 1'b1;
					end else if (halt_q) begin
						decay_d = DecayMax;
					end
				end
			end
			REQ_HALF: begin
				if (!halt_q && length_q != '0) begin
					length_d = length_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Result reflects the state after this word's update.
	always_comb begin
		res.length_active = (length_d != '0);
		res.level         = '0;
		if (en_d && res.length_active && !shift_d[0]) begin
			res.level = const_d ? volper_d : decay_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= LfsrW'(1);
			short_q   <= 1'b0;
			pcount_q  <= '0;
			preload_q <= '0;
			length_q  <= '0;
			halt_q    <= 1'b0;
			const_q   <= 1'b0;
			volper_q  <= '0;
			estart_q  <= 1'b0;
			decay_q   <= '0;
			div_q     <= '0;
			en_q      <= 1'b0;
		end else if (acc) begin
			shift_q   <= shift_d;
			short_q   <= short_d;
			pcount_q  <= pcount_d;
			preload_q <= preload_d;
			length_q  <= length_d;
			halt_q    <= halt_d;
			const_q   <= const_d;
			volper_q  <= volper_d;
			estart_q  <= estart_d;
			decay_q   <= decay_d;
			div_q     <= div_d;
			en_q      <= en_d;
		end
	end

	`ASSERT_IMPL(a_lfsr_nonzero, clk, arst_n, 1'b1, shift_q != '0)
	`ASSERT_IMPL(a_length_needs_enable, clk, arst_n, length_q != '0, en_q)

endmodule

FILE: rtl/noise_lfsr_sound_channel_unit.sv
// Top level of the noise sound channel: channel state plus output buffer.
// Depends on nlsc_pkg, nlsc_chan and assert_macros.svh.
// Accepted results are registered in the output buffer (main entry, or
// skid entry while stalled). Throughput: one word per cycle while the skid
// entry is empty; the state update is combinational and the two-entry
// buffer decouples the sides. Reset (arst_n low, asynchronous) restores the
// channel state (LFSR = 1, all else zero) and empties the output buffer.
`include "assert_macros.svh"

module noise_lfsr_sound_channel_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic [1:0] reg_sel,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] level,
	output logic       length_active
);
	import nlsc_pkg::*;

	logic    acc;
	result_t res;
	result_t out_q, skid_q;
	logic    out_v_q, skid_v_q;

	// Ready drops only while the skid entry is occupied.
	assign in_ready = !skid_v_q;
	assign acc      = in_valid && in_ready;

	// Channel state commits on accept; res is the post-update result.
	nlsc_chan u_chan (
		.clk        (clk),
		.arst_n     (arst_n),
		.acc        (acc),
		.req_type   (req_type),
		.reg_sel    (reg_sel),
		.write_data (write_data),
		.res        (res)
	);

	// Valid bits of the output buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_v_q && out_ready) begin
			// Main entry drains; refill from skid or a new word.
			out_v_q  <= skid_v_q || acc;
			skid_v_q <= 1'b0;
		end else if (out_v_q) begin
			// Stalled: a new word parks in the skid entry.
			if (acc) begin
				skid_v_q <= 1'b1;
			end
		end else begin
			out_v_q <= acc;
		end
	end

	// Payload of the output buffer, no reset needed.
	always_ff @(posedge clk) begin
		if (out_v_q && out_ready) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (acc) begin
				out_q <= res;
			end
		end else if (out_v_q) begin
			if (acc) begin
				skid_q <= res;
			end
		end else if (acc) begin
			out_q <= res;
		end
	end

	assign out_valid     = out_v_q;
	assign level         = out_q.level;
	assign length_active = out_q.length_active;

	`ASSERT_IMPL(a_skid_behind_main, clk, arst_n, skid_v_q, out_v_q)
	`ASSERT_NEXT(a_accept_gives_word, clk, arst_n, acc, out_v_q)
	`ASSERT_IMPL(a_level_needs_length, clk, arst_n, out_v_q && (level != '0), length_active)

endmodule

FILE: verif/noise_lfsr_sound_channel_unit_tb.sv
// Testbench for the noise sound channel: directed event sequences, then random traffic.
// Depends on nlsc_pkg and noise_lfsr_sound_channel_unit.
// An internal channel model predicts every result; it is checked in order, field by field.
`timescale 1ns / 1ps

module noise_lfsr_sound_channel_unit_tb;
	import nlsc_pkg::*;

	// req_type codes 5..7 are not events; the block must leave its state alone
	localparam logic [2:0] REQ_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] REQ_UNKNOWN_HI = 3'd7;

	logic       clk;
	logic       arst_n     = 1'b0;
	logic       in_valid   = 1'b0;
	logic       in_ready;
	logic [2:0] req_type   = 3'd0;
	logic [1:0] reg_sel    = 2'd0;
	logic [7:0] write_data = 8'd0;
	logic       out_valid;
	logic       out_ready  = 1'b0;
	logic [3:0] level;
	logic       length_active;

	// calm = no idling on either side
	logic calm = 1'b0;

	int unsigned words_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned nonzero_levels  = 0;
	int unsigned mismatch_count  = 0;

	// results predicted for accepted words, oldest first
	result_t expected_levels[$];

	// channel model state, at reset values
	logic [LfsrW-1:0]   lfsr          = 15'd1;
	logic               short_taps    = 1'b0;
	logic [PeriodW-1:0] timer_count   = '0;
	logic [PeriodW-1:0] timer_reload  = '0;
	logic [LengthW-1:0] length_left   = '0;
	logic               halt_flag     = 1'b0;
	logic               const_vol     = 1'b0;
	logic [3:0]         vol_or_period = '0;
	logic               env_restart   = 1'b0;
	logic [3:0]         env_level     = '0;
	logic [3:0]         env_div       = '0;
	logic               enabled       = 1'b0;

	logic [PeriodW-1:0] period_steps [16] = '{
		12'd4, 12'd8, 12'd16, 12'd32, 12'd64, 12'd96, 12'd128, 12'd160,
		12'd202, 12'd254, 12'd380, 12'd508, 12'd762, 12'd1016, 12'd2034, 12'd4068
	};
	logic [LengthW-1:0] length_loads [32] = '{
		8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
		8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
		8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
		8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
	};

	noise_lfsr_sound_channel_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.reg_sel       (reg_sel),
		.write_data    (write_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.level         (level),
		.length_active (length_active)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Applies one event to the model and returns the level/status it leaves.
	function automatic result_t step_noise_channel(logic [2:0] kind, logic [1:0] sel,
			logic [7:0] data);
		logic    tap;
		result_t r;
		case (kind)
			REQ_REG_WRITE: begin
				case (sel)
					REG_VOLUME: begin
						halt_flag     = data[5];
						const_vol     = data[4];
						vol_or_period = data[3:0];
					end
					REG_MODE: begin
						short_taps   = data[7];
						timer_reload = period_steps[data[3:0]];
					end
					REG_LENGTH: begin
						// length only loads while enabled; envelope restart regardless
						if (enabled)
							length_left = length_loads[data[7:3]];
						env_restart = 1'b1;
					end
					default: ;
				endcase
			end
			REQ_ENABLE: begin
				enabled = data[0];
				if (!data[0])
					length_left = '0;
			end
			REQ_TIMER: begin
				// LFSR steps only when the period counter wraps
				if (timer_count == '0) begin
					timer_count = timer_reload;
					tap  = (short_taps ? lfsr[6] : lfsr[1]) ^ lfsr[0];
					lfsr = {tap, lfsr[LfsrW-1:1]};
				end else begin
					timer_count = timer_count - 1'b1;
				end
			end
			REQ_QUARTER: begin
				if (env_restart) begin
					env_restart = 1'b0;
					env_level   = DecayMax;
					env_div     = vol_or_period;
				end else if (env_div != '0) begin
					env_div = env_div - 1'b1;
				end else begin
					env_div = vol_or_period;
					if (env_level != '0)
						env_level = env_level - 1'b1;
					else if (halt_flag)
						env_level = DecayMax;
				end
			end
			REQ_HALF: begin
				if (!halt_flag && length_left != '0)
					length_left = length_left - 1'b1;
			end
			default: ;
		endcase
		r.level = '0;
		if (enabled && length_left != '0 && !lfsr[0])
			r.level = const_vol ? vol_or_period : env_level;
		r.length_active = (length_left != '0);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, want %0d (t=%0t)", what, got, want, $time);
		mismatch_count++;
	endtask

	// Output side: random backpressure, none while calm.
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= 14);

	// Scoreboard. Results are registered, so the result delivered at an edge is
	// never from the word accepted at that same edge: check first, then predict.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_levels.size() == 0) begin
					report_mismatch("result with nothing pending", level, 0);
				end else begin
					if (level != expected_levels[0].level)
						report_mismatch("level", level, expected_levels[0].level);
					if (length_active != expected_levels[0].length_active)
						report_mismatch("length_active", length_active,
							expected_levels[0].length_active);
					void'(expected_levels.pop_front());
					results_checked++;
					if (level != '0)
						nonzero_levels++;
				end
			end
			if (in_valid && in_ready)
				expected_levels.push_back(step_noise_channel(req_type, reg_sel, write_data));
		end
	end

	// Sends one word: random idle cycles first, then holds it until accepted.
	task automatic send_word(input logic [2:0] kind, input logic [1:0] sel,
			input logic [7:0] data);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		reg_sel    <= sel;
		write_data <= data;
		do
			@(posedge clk);
		while (!in_ready);
		words_sent++;
	endtask

	// Fresh out of reset: count is 0 and reload 0, so a timer clock shifts at once.
	// Codes 5..7 must leave everything untouched.
	task automatic test_power_on;
		send_word(REQ_TIMER, 2'd3, 8'hFF);
		send_word(REQ_UNKNOWN_LO, 2'd0, 8'h00);
		send_word(REQ_UNKNOWN_HI, 2'd3, 8'hFF);
	endtask

	// Length load ignored while disabled, enable bit0 only, disable clears length.
	task automatic test_length_gate;
		send_word(REQ_REG_WRITE, REG_LENGTH, 8'hFF);
		send_word(REQ_ENABLE, 2'd3, 8'hFE);
		send_word(REQ_ENABLE, 2'd0, 8'h01);
		send_word(REQ_REG_WRITE, REG_LENGTH, 8'h08);
		send_word(REQ_ENABLE, 2'd0, 8'h00);
		send_word(REQ_ENABLE, 2'd0, 8'hFF);
		send_word(REQ_REG_WRITE, REG_LENGTH, 8'h07);
	endtask

	// All-ones and unused-bit patterns on the volume and mode registers, plus the unused slot.
	task automatic test_registers;
		send_word(REQ_REG_WRITE, REG_VOLUME, 8'hFF);
		send_word(REQ_REG_WRITE, REG_UNUSED, 8'hFF);
		send_word(REQ_REG_WRITE, REG_MODE, 8'hFF);
		send_word(REQ_REG_WRITE, REG_MODE, 8'h70);
		send_word(REQ_REG_WRITE, REG_VOLUME, 8'h1F);
	endtask

	// Envelope restart, decay with period 0, length countdown, upper volume bits.
	task automatic test_envelope;
		send_word(REQ_QUARTER, 2'd0, 8'h00);
		send_word(REQ_REG_WRITE, REG_VOLUME, 8'h00);
		send_word(REQ_QUARTER, 2'd0, 8'h00);
		send_word(REQ_HALF, 2'd0, 8'h00);
		send_word(REQ_REG_WRITE, REG_VOLUME, 8'hC0);
	endtask

	// Timer reload from the table with the long feedback tap, then a short-tap mode write.
	task automatic test_timer_lfsr;
		send_word(REQ_TIMER, 2'd0, 8'h00);
		send_word(REQ_REG_WRITE, REG_MODE, 8'h80);
		send_word(REQ_TIMER, 2'd0, 8'h00);
	endtask

	// Mostly well-formed play: enabled channel, short periods, lots of clocks.
	// Long periods are only written and then overwritten so the LFSR keeps moving.
	task automatic test_random_traffic(input int unsigned count);
		int unsigned n;
		int unsigned pick;
		logic [3:0]  idx;
		for (n = 0; n < count; n++) begin
			calm = (n >= 200 && n < 320);
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				send_word(REQ_TIMER, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else if (pick < 52) begin
				send_word(REQ_QUARTER, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else if (pick < 61) begin
				send_word(REQ_HALF, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else if (pick < 69) begin
				send_word(REQ_REG_WRITE, REG_VOLUME, 8'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				idx = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 3))
					: 4'($urandom_range(4, 7));
				send_word(REQ_REG_WRITE, REG_MODE, {4'($urandom_range(0, 15)), idx});
			end else if (pick < 77) begin
				send_word(REQ_REG_WRITE, REG_MODE, {4'($urandom_range(0, 15)),
					4'($urandom_range(8, 15))});
				send_word(REQ_REG_WRITE, REG_MODE, {4'($urandom_range(0, 15)),
					4'($urandom_range(0, 1))});
			end else if (pick < 85) begin
				send_word(REQ_REG_WRITE, REG_LENGTH, 8'($urandom_range(0, 255)));
			end else if (pick < 90) begin
				send_word(REQ_ENABLE, 2'($urandom_range(0, 3)),
					{7'($urandom_range(0, 127)), 1'($urandom_range(0, 9) != 0)});
			end else if (pick < 93) begin
				send_word(REQ_REG_WRITE, REG_UNUSED, 8'($urandom_range(0, 255)));
			end else if (pick < 96) begin
				send_word(3'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI)),
					2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				send_word(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)));
			end
		end
		calm = 1'b0;
	endtask

	initial begin
		int unsigned drain;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_power_on;
		test_length_gate;
		test_registers;
		test_envelope;
		test_timer_lfsr;
		test_random_traffic(500);

		@(negedge clk);
		in_valid <= 1'b0;

		// let outstanding results drain, bounded
		for (drain = 0; drain < 2000 && expected_levels.size() != 0; drain++)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (expected_levels.size() != 0)
			report_mismatch("results never delivered", 0, expected_levels.size());

		$display("Covered register/enable writes, timer, quarter and half frame clocks, unknown codes.");
		$display("%0d words sent, %0d results checked, %0d audible, %0d mismatches.",
			words_sent, results_checked, nonzero_levels, mismatch_count);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Hard stop if the run does not finish.
	initial begin
		#200000;
		$display("Watchdog expired, %0d results still pending.", expected_levels.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/nlsc_pkg.sv
rtl/nlsc_chan.sv
rtl/noise_lfsr_sound_channel_unit.sv
verif/noise_lfsr_sound_channel_unit_tb.sv
